/* rtl/spcf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spcf_pkg;

  // Default fraction bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_BALL_RADIUS     = 3'd0;
  localparam logic [2:0] REG_SPRING_GAIN     = 3'd1;
  localparam logic [2:0] REG_DAMPING_GAIN    = 3'd2;
  localparam logic [2:0] REG_SHEAR_GAIN      = 3'd3;
  localparam logic [2:0] REG_ATTRACTION_GAIN = 3'd4;

  // Register reset values
  localparam logic [30:0] RST_BALL_RADIUS     = 31'd32768;
  localparam logic [31:0] RST_SPRING_GAIN     = 32'd32768;
  localparam logic [31:0] RST_DAMPING_GAIN    = 32'd1311;
  localparam logic [31:0] RST_SHEAR_GAIN      = 32'd6554;
  localparam logic [31:0] RST_ATTRACTION_GAIN = 32'd0;

  // floor(x / 1000) for a 31 bit x as (x * EPS_MUL) >> EPS_SHIFT
  localparam logic [31:0] EPS_MUL   = 32'd2199023256;
  localparam int          EPS_SHIFT = 41;

  // Number of square root digit steps for a 64 bit radicand
  localparam int SQRT_STEPS = 32;

  // Tangential velocity clamp
  localparam logic signed [71:0] TAN_LIM = 72'sd4294967295;

  // Fields carried along the pipeline
  typedef struct packed {
    logic [2:0][31:0] pa;
    logic [2:0][31:0] pb;
    logic [2:0][32:0] r;
    logic [2:0][32:0] v;
    logic             hit;
  } carry_t;

  // One finished result word
  typedef struct packed {
    logic             collided;
    logic [2:0][31:0] new_b;
    logic [2:0][31:0] new_a;
    logic [2:0][31:0] force_v;
  } result_t;

  // Saturate to 32 bit signed
  function automatic logic [31:0] sat32(input logic signed [71:0] x);
    logic [31:0] y;
    if (x > 72'sd2147483647) begin
      y = 32'h7fff_ffff;
    end else if (x < -72'sd2147483648) begin
      y = 32'h8000_0000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

endpackage

`default_nettype wire

/* rtl/sphere_pair_collision_force.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sphere pair contact force.
// Slave stream: one word per sphere pair (positions and velocities of A
// and B). Master stream: one word per pair with the contact force, both
// pushed positions and, on tuser, the collision flag.
// The APB port sets radius and gains; write it only while the block idles.
// Pipeline from acceptance to a valid result word:
// three input stages, 32 stages of the square root (one result bit each),
// FRAC_BITS + 2 stages of the three normal dividers (a load stage and
// then one quotient bit each), seven stages of gain products and then
// the output register. Throughput is one pair per cycle while nothing stalls.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls, a skid register takes one more word; then the
// whole pipeline holds and s_tready falls until the output drains.
module sphere_pair_collision_force
  import spcf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  // pos_a_x, pos_a_y, pos_a_z, vel_a_x, vel_a_y, vel_a_z,
  // pos_b_x, pos_b_y, pos_b_z, vel_b_x, vel_b_y, vel_b_z (32 bits each)
  input  wire  [383:0] s_tdata,
  input  wire          s_tvalid,
  output logic         s_tready,
  // force_x, force_y, force_z, new_a_x, new_a_y, new_a_z,
  // new_b_x, new_b_y, new_b_z (32 bits each)
  output logic [287:0] m_tdata,
  // collided
  output logic [0:0]   m_tuser,
  output logic         m_tvalid,
  input  wire          m_tready,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [4:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int NW    = FRAC_BITS + 2;      // normal component width
  localparam int QW    = FRAC_BITS + 1;      // quotient magnitude width
  localparam int DVN   = FRAC_BITS + 1;      // divider steps
  localparam int VNW   = 33 + NW;
  localparam int DOTW  = 35 + NW - FRAC_BITS;
  localparam int MMW   = NW + 34;
  localparam int DNW   = DOTW + NW;
  localparam int SPNW  = 32 + NW;

  // ---------------------------------------------------------------- config
  logic [30:0] ball_radius;
  logic [31:0] spring_gain;
  logic [31:0] damping_gain;
  logic [31:0] shear_gain;
  logic [31:0] attraction_gain;
  logic [31:0] contact_dist;
  logic [63:0] contact_dist2;
  logic [63:0] eps_prod;
  logic [31:0] sep_eps;

  assign pready = 1'b1;

  // Write a register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      ball_radius     <= RST_BALL_RADIUS;
      spring_gain     <= RST_SPRING_GAIN;
      damping_gain    <= RST_DAMPING_GAIN;
      shear_gain      <= RST_SHEAR_GAIN;
      attraction_gain <= RST_ATTRACTION_GAIN;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_BALL_RADIUS:     ball_radius     <= pwdata[30:0];
        REG_SPRING_GAIN:     spring_gain     <= pwdata;
        REG_DAMPING_GAIN:    damping_gain    <= pwdata;
        REG_SHEAR_GAIN:      shear_gain      <= pwdata;
        REG_ATTRACTION_GAIN: attraction_gain <= pwdata;
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (paddr[4:2])
      REG_BALL_RADIUS:     prdata = {1'b0, ball_radius};
      REG_SPRING_GAIN:     prdata = spring_gain;
      REG_DAMPING_GAIN:    prdata = damping_gain;
      REG_SHEAR_GAIN:      prdata = shear_gain;
      REG_ATTRACTION_GAIN: prdata = attraction_gain;
      default:             prdata = 32'd0;
    endcase
  end

  // Derive contact distance, its square and the separation epsilon
  always_ff @(posedge clk) begin
    contact_dist  <= {ball_radius, 1'b0};
    contact_dist2 <= contact_dist * contact_dist;
    eps_prod      <= {33'd0, ball_radius} * {32'd0, EPS_MUL};
    sep_eps       <= 32'(eps_prod >> EPS_SHIFT);
  end

  // ---------------------------------------------------------------- flow
  logic    en;
  logic    skid_v;
  logic    main_v;
  result_t skid_w;
  result_t main_w;

  assign en       = !skid_v;
  assign s_tready = en;

  // ---------------------------------------------------------------- input
  logic             s1_v;
  carry_t           s1_c;
  logic [2:0][31:0] s1_absr;
  logic             s2_v;
  carry_t           s2_c;
  logic [2:0][63:0] s2_sq;

  // Register fields, differences and their magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [32:0] rd;
        rd = 33'($signed(s_tdata[192 + 32*i +: 32])) - 33'($signed(s_tdata[32*i +: 32]));
        s1_c.pa[i] <= s_tdata[32*i +: 32];
        s1_c.pb[i] <= s_tdata[192 + 32*i +: 32];
        s1_c.r[i]  <= rd;
        s1_c.v[i]  <= 33'($signed(s_tdata[288 + 32*i +: 32]))
                    - 33'($signed(s_tdata[96 + 32*i +: 32]));
        s1_absr[i] <= rd[32] ? 32'(-rd) : rd[31:0];
      end
      s1_c.hit <= 1'b0;
    end
  end

  // Square each component
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_c <= s1_c;
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= {32'd0, s1_absr[i]} * {32'd0, s1_absr[i]};
      end
    end
  end

  // ---------------------------------------------------------------- sqrt
  logic        sq_v    [0:SQRT_STEPS];
  carry_t      sq_c    [0:SQRT_STEPS];
  logic [63:0] sq_d    [0:SQRT_STEPS];
  logic [32:0] sq_rem  [0:SQRT_STEPS];
  logic [31:0] sq_root [0:SQRT_STEPS];

  // Sum the squares with saturation and test for contact
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic [65:0] sum;
      logic [63:0] d2;
      carry_t      c;
      sum = {2'b00, s2_sq[0]} + {2'b00, s2_sq[1]} + {2'b00, s2_sq[2]};
      d2  = (sum[65:64] != 2'b00) ? '1 : sum[63:0];
      c     = s2_c;
      c.hit = d2 < contact_dist2;
      sq_c[0]     <= c;
      sq_d[0]     <= d2;
      sq_rem[0]   <= '0;
      sq_root[0]  <= '0;
    end
  end

  // Take one root bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [34:0] acc;
    logic [34:0] trial;
    assign acc   = {sq_rem[k], sq_d[k][63:62]};
    assign trial = {1'b0, sq_root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (acc >= trial) begin
          sq_rem[k+1]  <= 33'(acc - trial);
          sq_root[k+1] <= {sq_root[k][30:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= acc[32:0];
          sq_root[k+1] <= {sq_root[k][30:0], 1'b0};
        end
        sq_d[k+1] <= {sq_d[k][61:0], 2'b00};
        sq_c[k+1] <= sq_c[k];
      end
    end
  end

  // ---------------------------------------------------------------- divide
  logic             dv_v    [0:DVN];
  carry_t           dv_c    [0:DVN];
  logic [31:0]      dv_dist [0:DVN];
  logic [31:0]      dv_pen  [0:DVN];
  logic [32:0]      dv_half [0:DVN];
  logic [2:0]       dv_neg  [0:DVN];
  logic [2:0][31:0] dv_rem  [0:DVN];
  logic [2:0][QW-1:0] dv_q  [0:DVN];

  // Load divider lanes with the magnitudes of the relative position
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic [31:0] pen;
      pen = contact_dist - sq_root[SQRT_STEPS];
      dv_c[0]    <= sq_c[SQRT_STEPS];
      dv_dist[0] <= sq_root[SQRT_STEPS];
      dv_pen[0]  <= pen;
      dv_half[0] <= {2'b00, pen[31:1]} + {1'b0, sep_eps};
      for (int i = 0; i < 3; i++) begin
        logic [32:0] ri;
        ri = sq_c[SQRT_STEPS].r[i];
        dv_neg[0][i] <= ri[32];
        dv_rem[0][i] <= ri[32] ? 32'(-ri) : ri[31:0];
        dv_q[0][i]   <= '0;
      end
    end
  end

  // Take one quotient bit per stage; the first step needs no shift
  for (genvar j = 0; j < DVN; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          logic [32:0] t;
          t = (j == 0) ? {1'b0, dv_rem[j][i]} : {dv_rem[j][i], 1'b0};
          if (t >= {1'b0, dv_dist[j]}) begin
            dv_rem[j+1][i] <= 32'(t - {1'b0, dv_dist[j]});
            dv_q[j+1][i]   <= {dv_q[j][i][QW-2:0], 1'b1};
          end else begin
            dv_rem[j+1][i] <= t[31:0];
            dv_q[j+1][i]   <= {dv_q[j][i][QW-2:0], 1'b0};
          end
        end
        dv_c[j+1]    <= dv_c[j];
        dv_dist[j+1] <= dv_dist[j];
        dv_pen[j+1]  <= dv_pen[j];
        dv_half[j+1] <= dv_half[j];
        dv_neg[j+1]  <= dv_neg[j];
      end
    end
  end

  // ---------------------------------------------------------------- products
  logic                    p0_v, p1_v, p2_v, p3_v, p4_v, p5_v, p6_v;
  carry_t                  p0_c, p1_c, p2_c, p3_c, p4_c, p5_c;
  logic signed [NW-1:0]    p0_n [3];
  logic signed [NW-1:0]    p1_n [3];
  logic signed [NW-1:0]    p2_n [3];
  logic [31:0]             p0_pen;
  logic [32:0]             p0_half;
  logic signed [VNW-1:0]   p1_vn [3];
  logic signed [64:0]      p1_sgp;
  logic signed [MMW-1:0]   p1_mm [3];
  logic signed [64:0]      p1_dmp [3];
  logic signed [64:0]      p1_att [3];
  logic signed [DOTW-1:0]  p2_dot;
  logic [31:0]             p2_sp;
  logic [2:0][31:0]        p2_da, p3_da, p4_da, p5_da;
  logic [2:0][31:0]        p2_aa, p3_aa, p4_aa, p5_aa;
  logic [2:0][31:0]        p2_na, p3_na, p4_na, p5_na;
  logic [2:0][31:0]        p2_nb, p3_nb, p4_nb, p5_nb;
  logic signed [DNW-1:0]   p3_dn [3];
  logic signed [SPNW-1:0]  p3_spn [3];
  logic signed [33:0]      p4_t [3];
  logic [2:0][31:0]        p4_st, p5_st;
  logic signed [65:0]      p5_sh [3];
  result_t                 p6_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
      p5_v <= 1'b0;
      p6_v <= 1'b0;
    end else if (en) begin
      p0_v <= dv_v[DVN];
      p1_v <= p0_v;
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;
      p5_v <= p4_v;
      p6_v <= p5_v;
    end
  end

  // Sign the normal; zero distance gives a zero normal
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [NW-1:0] q;
        q = $signed({1'b0, dv_q[DVN][i]});
        if (dv_dist[DVN] == 32'd0) begin
          p0_n[i] <= '0;
        end else begin
          p0_n[i] <= dv_neg[DVN][i] ? -q : q;
        end
      end
      p0_c    <= dv_c[DVN];
      p0_pen  <= dv_pen[DVN];
      p0_half <= dv_half[DVN];
    end
  end

  // Form the first products
  always_ff @(posedge clk) begin
    if (en) begin
      p1_sgp <= $signed(spring_gain) * $signed({1'b0, p0_pen});
      for (int i = 0; i < 3; i++) begin
        p1_vn[i]  <= $signed(p0_c.v[i]) * p0_n[i];
        p1_mm[i]  <= p0_n[i] * $signed({1'b0, p0_half});
        p1_dmp[i] <= $signed(damping_gain) * $signed(p0_c.v[i]);
        p1_att[i] <= $signed(attraction_gain) * $signed(p0_c.r[i]);
        p1_n[i]   <= p0_n[i];
      end
      p1_c <= p0_c;
    end
  end

  // Reduce the dot product, scale the spring, damping and attraction terms and push the positions
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [VNW+1:0] vsum;
      vsum   = (VNW+2)'(p1_vn[0]) + (VNW+2)'(p1_vn[1]) + (VNW+2)'(p1_vn[2]);
      p2_dot <= DOTW'(vsum >>> FRAC_BITS);
      p2_sp  <= sat32(72'(p1_sgp >>> FRAC_BITS));
      for (int i = 0; i < 3; i++) begin
        logic signed [MMW-1:0] m;
        m = p1_mm[i] >>> FRAC_BITS;
        p2_da[i] <= sat32(72'(p1_dmp[i] >>> FRAC_BITS));
        p2_aa[i] <= sat32(72'(p1_att[i] >>> FRAC_BITS));
        if (p1_c.hit) begin
          p2_na[i] <= sat32(72'($signed(p1_c.pa[i])) - 72'(m));
          p2_nb[i] <= sat32(72'($signed(p1_c.pb[i])) + 72'(m));
        end else begin
          p2_na[i] <= p1_c.pa[i];
          p2_nb[i] <= p1_c.pb[i];
        end
        p2_n[i] <= p1_n[i];
      end
      p2_c <= p1_c;
    end
  end

  // Project the dot product and the spring back onto the normal
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p3_dn[i]  <= p2_dot * p2_n[i];
        p3_spn[i] <= $signed(p2_sp) * p2_n[i];
      end
      p3_c  <= p2_c;
      p3_da <= p2_da;
      p3_aa <= p2_aa;
      p3_na <= p2_na;
      p3_nb <= p2_nb;
    end
  end

  // Form the clamped tangential velocity and the spring term
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [71:0] tv;
        tv = 72'($signed(p3_c.v[i])) - 72'(p3_dn[i] >>> FRAC_BITS);
        if (tv > TAN_LIM) begin
          p4_t[i] <= 34'(TAN_LIM);
        end else if (tv < -TAN_LIM) begin
          p4_t[i] <= 34'(-TAN_LIM);
        end else begin
          p4_t[i] <= 34'(tv);
        end
        p4_st[i] <= sat32(-72'(p3_spn[i] >>> FRAC_BITS));
      end
      p4_c  <= p3_c;
      p4_da <= p3_da;
      p4_aa <= p3_aa;
      p4_na <= p3_na;
      p4_nb <= p3_nb;
    end
  end

  // Scale the tangential velocity by the shear gain
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p5_sh[i] <= $signed(shear_gain) * p4_t[i];
      end
      p5_c  <= p4_c;
      p5_st <= p4_st;
      p5_da <= p4_da;
      p5_aa <= p4_aa;
      p5_na <= p4_na;
      p5_nb <= p4_nb;
    end
  end

  // Add the four terms; no contact gives zero force
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [71:0] sum;
        sum = 72'($signed(p5_st[i])) + 72'($signed(p5_da[i]))
            + 72'($signed(sat32(72'(p5_sh[i] >>> FRAC_BITS))))
            + 72'($signed(p5_aa[i]));
        p6_w.force_v[i] <= p5_c.hit ? sat32(sum) : 32'd0;
      end
      p6_w.new_a    <= p5_na;
      p6_w.new_b    <= p5_nb;
      p6_w.collided <= p5_c.hit;
    end
  end

  // ---------------------------------------------------------------- output
  // Hold the output word, and park one more in the skid when it stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (main_v && m_tready) begin
        if (skid_v) begin
          main_v <= 1'b1;
          skid_v <= 1'b0;
        end else begin
          main_v <= en && p6_v;
        end
      end else if (en && p6_v) begin
        if (main_v) begin
          skid_v <= 1'b1;
        end else begin
          main_v <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_v && m_tready) begin
      main_w <= skid_v ? skid_w : p6_w;
    end else if (!main_v) begin
      main_w <= p6_w;
    end
    if (en && p6_v && main_v && !m_tready) begin
      skid_w <= p6_w;
    end
  end

  assign m_tvalid = main_v;
  assign m_tdata  = {main_w.new_b, main_w.new_a, main_w.force_v};
  assign m_tuser  = main_w.collided;

endmodule

`default_nettype wire
